>>> hdl/mmlps_pkg.sv
// Shared types, constants and character helpers for the memory-map line parser.
package mmlps_pkg;

    localparam int unsigned MAX_PATH_CAP = 4096;
    localparam int unsigned CAP_W        = 13;
    localparam int unsigned CNT_W        = 12;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_W_LO  = 8'h77;
    localparam logic [7:0] CH_P_LO  = 8'h70;

    // Configuration register indexes.
    localparam logic REG_PATH_CAP  = 1'b0;
    localparam logic REG_ANON_EXEC = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

    // Score terms.
    localparam logic [6:0] SC_BASE = 7'd35;
    localparam logic [6:0] SC_ANON = 7'd45;
    localparam logic [6:0] SC_RWX  = 7'd28;
    localparam logic [6:0] SC_SIZE_MAX = 7'd18;
    localparam logic [63:0] SZ_MIN = 64'd4096;
    localparam logic [63:0] SZ_MAX = 64'd268435456;

    typedef enum logic [11:0] {
        PH_LOW_START  = 12'h001,
        PH_LOW_ZERO   = 12'h002,
        PH_LOW_PFX    = 12'h004,
        PH_LOW_DIG    = 12'h008,
        PH_HIGH_START = 12'h010,
        PH_HIGH_ZERO  = 12'h020,
        PH_HIGH_PFX   = 12'h040,
        PH_HIGH_DIG   = 12'h080,
        PH_SEEK       = 12'h100,
        PH_GAP        = 12'h200,
        PH_FIELD      = 12'h400,
        PH_PATH       = 12'h800
    } t_phase;

    typedef enum logic [1:0] {
        PM_WAIT = 2'd0,
        PM_CAPT = 2'd1,
        PM_DONE = 2'd2
    } t_perm_mode;

    // Line summary handed to the scorer.
    typedef struct packed {
        logic [63:0]      low_addr;
        logic [63:0]      high_addr;
        logic [31:0]      perm_chars;
        logic [2:0]       perm_count;
        logic [CNT_W-1:0] path_count;
        logic             path_bracket;
    } t_line;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)      h.value = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) h.value = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) h.value = 4'(c - 8'h37);
        else                               h.valid = 1'b0;
        return h;
    endfunction

    function automatic logic is_sp_tab(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_wide_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
               (c == CH_CR);
    endfunction

    // Shift in one hex digit, saturating to all ones on overflow.
    function automatic logic [63:0] acc_hex(input logic [63:0] acc, input logic [3:0] d);
        if (acc[63:60] != 4'd0) return '1;
        return {acc[59:0], d};
    endfunction

endpackage

>>> hdl/mmlps_score.sv
// Suspicion score of one parsed memory-map line.
module mmlps_score (
    input  mmlps_pkg::t_line i_line,
    input  logic             i_anon_only,
    output logic [6:0]       o_score
);

    logic [63:0] w_size;
    logic [8:0]  w_mib;
    logic [6:0]  w_size_add;
    logic        w_anon;
    logic        w_exec_priv;
    logic        w_rw;

    always_comb begin
        w_size = (i_line.high_addr > i_line.low_addr) ?
                 (i_line.high_addr - i_line.low_addr) : 64'd0;
        w_mib  = w_size[28:20];
        if (w_size >= mmlps_pkg::SZ_MIN && w_size <= mmlps_pkg::SZ_MAX) begin
            w_size_add = (w_mib > 9'(mmlps_pkg::SC_SIZE_MAX)) ?
                         mmlps_pkg::SC_SIZE_MAX : w_mib[6:0];
        end else begin
            w_size_add = 7'd0;
        end
        w_anon      = (i_line.path_count == '0) || i_line.path_bracket;
        w_exec_priv = (i_line.perm_count == 3'd4) &&
                      (i_line.perm_chars[23:16] == mmlps_pkg::CH_X_LO) &&
                      (i_line.perm_chars[31:24] == mmlps_pkg::CH_P_LO);
        w_rw        = (i_line.perm_chars[7:0] == mmlps_pkg::CH_R_LO) &&
                      (i_line.perm_chars[15:8] == mmlps_pkg::CH_W_LO);
        if (!w_exec_priv || (i_anon_only && !w_anon)) begin
            o_score = 7'd0;
        end else begin
            o_score = mmlps_pkg::SC_BASE + (w_anon ? mmlps_pkg::SC_ANON : 7'd0) +
                      (w_rw ? mmlps_pkg::SC_RWX : 7'd0) + w_size_add;
        end
    end

endmodule

>>> hdl/memory_map_line_parse_score.sv
// Top level: memory-map line parser, path copier and suspicion scorer.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------------
//  char      | in        | i_char_valid / o_char_ready  | i_char_in
//  result    | out       | o_res_valid / i_res_ready    | o_kind .. o_path_length
//  config    | in        | i_cfg_wr_en (no wait)        | i_cfg_idx, i_cfg_data
//
// One character per cycle, sustained while no result is held stalled. Each request updates the parse state
// in the cycle it is accepted; any result it causes lands in the output
// register at that same edge and is offered from the next cycle on.
// The output register frees up in the cycle it is taken, so a stalled result
// holds off only the following character, not the one being drained.
// Reset (synchronous, active low) puts the parser at line start with empty
// accumulators, restores path capacity 256 and clears the anonymous-only filter.
module memory_map_line_parse_score (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character requests
    input  logic        i_char_valid,
    output logic        o_char_ready,
    input  logic [7:0]  i_char_in,
    // results
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_kind,
    output logic [7:0]  o_path_byte,
    output logic [63:0] o_low_addr,
    output logic [63:0] o_high_addr,
    output logic [31:0] o_perm_chars,
    output logic [2:0]  o_perm_count,
    output logic        o_parse_ok,
    output logic [6:0]  o_score,
    output logic [11:0] o_path_length,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    // configuration
    logic [12:0] r_path_cap;
    logic        r_anon_only;

    // per-line parse state
    mmlps_pkg::t_phase     r_phase,   n_phase;
    logic [63:0]           r_low,     n_low;
    logic [63:0]           r_high,    n_high;
    logic [31:0]           r_perm,    n_perm;
    logic [2:0]            r_perm_seen, n_perm_seen;
    logic [11:0]           r_path_count, n_path_count;
    logic                  r_bracket, n_bracket;
    logic                  r_failed,  n_failed;
    logic [2:0]            r_field,   n_field;
    mmlps_pkg::t_perm_mode r_pmode,   n_pmode;

    // output register
    logic        r_out_valid;
    logic        r_kind;
    logic [7:0]  r_path_byte;
    logic [63:0] r_low_out;
    logic [63:0] r_high_out;
    logic [31:0] r_perm_out;
    logic [2:0]  r_perm_cnt_out;
    logic        r_ok_out;
    logic [6:0]  r_score_out;
    logic [11:0] r_len_out;

    logic             w_accept;
    logic             w_eol;
    logic             w_emit;
    logic             w_ok;
    logic [12:0]      w_cap;
    mmlps_pkg::t_hex  w_hex;
    mmlps_pkg::t_line w_line;
    logic [6:0]       w_score;
    logic [7:0]       c;

    assign o_char_ready = !r_out_valid || i_res_ready;
    assign w_accept     = i_char_valid && o_char_ready;
    assign c            = i_char_in;
    assign w_hex        = mmlps_pkg::hex_digit(c);
    assign w_cap        = (r_path_cap > 13'(mmlps_pkg::MAX_PATH_CAP)) ?
                          13'(mmlps_pkg::MAX_PATH_CAP) : r_path_cap;
    assign w_eol        = (c == mmlps_pkg::CH_NUL) || (c == mmlps_pkg::CH_LF);
    assign w_ok         = !r_failed && r_perm_seen != 3'd0 &&
                          (r_phase == mmlps_pkg::PH_GAP || r_phase == mmlps_pkg::PH_FIELD ||
                           r_phase == mmlps_pkg::PH_PATH);

    assign w_line.low_addr     = r_low;
    assign w_line.high_addr    = r_high;
    assign w_line.perm_chars   = r_perm;
    assign w_line.perm_count   = r_perm_seen;
    assign w_line.path_count   = r_path_count;
    assign w_line.path_bracket = r_bracket;

    mmlps_score u_score (
        .i_line      (w_line),
        .i_anon_only (r_anon_only),
        .o_score     (w_score)
    );

    // Permission capture: skip leading blanks, keep up to four characters,
    // stop at the next blank. Runs alongside the field walk.
    function automatic void perm_feed(input logic [7:0] ch,
                                      inout mmlps_pkg::t_perm_mode mode,
                                      inout logic [31:0] store,
                                      inout logic [2:0] seen);
        if (mode != mmlps_pkg::PM_DONE) begin
            if (mmlps_pkg::is_wide_space(ch)) begin
                if (mode == mmlps_pkg::PM_CAPT) mode = mmlps_pkg::PM_DONE;
            end else begin
                mode = mmlps_pkg::PM_CAPT;
                if (seen < 3'd4) begin
                    store[8*seen[1:0] +: 8] = ch;
                    seen = seen + 3'd1;
                end
                if (seen >= 3'd4) mode = mmlps_pkg::PM_DONE;
            end
        end
    endfunction

    always_comb begin
        n_phase      = r_phase;
        n_low        = r_low;
        n_high       = r_high;
        n_perm       = r_perm;
        n_perm_seen  = r_perm_seen;
        n_path_count = r_path_count;
        n_bracket    = r_bracket;
        n_failed     = r_failed;
        n_field      = r_field;
        n_pmode      = r_pmode;
        w_emit       = 1'b0;

        if (w_eol) begin
            n_phase      = mmlps_pkg::PH_LOW_START;
            n_low        = '0;
            n_high       = '0;
            n_perm       = '0;
            n_perm_seen  = '0;
            n_path_count = '0;
            n_bracket    = 1'b0;
            n_failed     = 1'b0;
            n_field      = '0;
            n_pmode      = mmlps_pkg::PM_WAIT;
        end else if (!r_failed) begin
            case (r_phase)
                mmlps_pkg::PH_LOW_START: begin
                    if (!mmlps_pkg::is_wide_space(c)) begin
                        if (c == mmlps_pkg::CH_ZERO) begin
                            n_phase = mmlps_pkg::PH_LOW_ZERO;
                        end else if (w_hex.valid) begin
                            n_low   = {60'd0, w_hex.value};
                            n_phase = mmlps_pkg::PH_LOW_DIG;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                end
                mmlps_pkg::PH_LOW_ZERO, mmlps_pkg::PH_LOW_PFX, mmlps_pkg::PH_LOW_DIG: begin
                    if (r_phase == mmlps_pkg::PH_LOW_ZERO &&
                        (c == mmlps_pkg::CH_X_LO || c == mmlps_pkg::CH_X_UP)) begin
                        n_phase = mmlps_pkg::PH_LOW_PFX;
                    end else if (w_hex.valid) begin
                        n_low   = mmlps_pkg::acc_hex(r_low, w_hex.value);
                        n_phase = mmlps_pkg::PH_LOW_DIG;
                    end else if (c == mmlps_pkg::CH_DASH) begin
                        n_phase = mmlps_pkg::PH_HIGH_START;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                mmlps_pkg::PH_HIGH_START: begin
                    if (c == mmlps_pkg::CH_ZERO) begin
                        n_phase = mmlps_pkg::PH_HIGH_ZERO;
                    end else if (w_hex.valid) begin
                        n_high  = {60'd0, w_hex.value};
                        n_phase = mmlps_pkg::PH_HIGH_DIG;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                mmlps_pkg::PH_HIGH_ZERO, mmlps_pkg::PH_HIGH_PFX, mmlps_pkg::PH_HIGH_DIG: begin
                    if (r_phase == mmlps_pkg::PH_HIGH_ZERO &&
                        (c == mmlps_pkg::CH_X_LO || c == mmlps_pkg::CH_X_UP)) begin
                        n_phase = mmlps_pkg::PH_HIGH_PFX;
                    end else if (w_hex.valid) begin
                        n_high  = mmlps_pkg::acc_hex(r_high, w_hex.value);
                        n_phase = mmlps_pkg::PH_HIGH_DIG;
                    end else if (c == mmlps_pkg::CH_SPACE) begin
                        n_phase = mmlps_pkg::PH_GAP;
                        n_field = '0;
                    end else begin
                        n_phase = mmlps_pkg::PH_SEEK;
                    end
                end
                mmlps_pkg::PH_SEEK: begin
                    if (c == mmlps_pkg::CH_SPACE) begin
                        n_phase = mmlps_pkg::PH_GAP;
                        n_field = '0;
                    end
                end
                mmlps_pkg::PH_GAP: begin
                    perm_feed(c, n_pmode, n_perm, n_perm_seen);
                    if (!mmlps_pkg::is_sp_tab(c)) begin
                        if (r_field >= 3'd4) begin
                            n_phase = mmlps_pkg::PH_PATH;
                            w_emit  = 1'b1;
                        end else begin
                            n_phase = mmlps_pkg::PH_FIELD;
                        end
                    end
                end
                mmlps_pkg::PH_FIELD: begin
                    perm_feed(c, n_pmode, n_perm, n_perm_seen);
                    if (mmlps_pkg::is_sp_tab(c)) begin
                        // field count only matters up to four
                        if (r_field < 3'd4) n_field = r_field + 3'd1;
                        n_phase = mmlps_pkg::PH_GAP;
                    end
                end
                mmlps_pkg::PH_PATH: begin
                    perm_feed(c, n_pmode, n_perm, n_perm_seen);
                    w_emit = 1'b1;
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end

        // Path byte goes out only while the buffer keeps one slot spare.
        if (w_emit) begin
            if (({1'b0, r_path_count} + 13'd1) >= w_cap) begin
                w_emit = 1'b0;
            end else begin
                if (r_path_count == '0) n_bracket = (c == mmlps_pkg::CH_LBRK);
                n_path_count = r_path_count + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_cap  <= mmlps_pkg::CAP_RESET;
            r_anon_only <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                mmlps_pkg::REG_PATH_CAP:  r_path_cap  <= i_cfg_data;
                mmlps_pkg::REG_ANON_EXEC: r_anon_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mmlps_pkg::PH_LOW_START;
            r_low        <= '0;
            r_high       <= '0;
            r_perm       <= '0;
            r_perm_seen  <= '0;
            r_path_count <= '0;
            r_bracket    <= 1'b0;
            r_failed     <= 1'b0;
            r_field      <= '0;
            r_pmode      <= mmlps_pkg::PM_WAIT;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_low        <= n_low;
            r_high       <= n_high;
            r_perm       <= n_perm;
            r_perm_seen  <= n_perm_seen;
            r_path_count <= n_path_count;
            r_bracket    <= n_bracket;
            r_failed     <= n_failed;
            r_field      <= n_field;
            r_pmode      <= n_pmode;
        end
    end

    // Result register: loads on an accepted request that produces a result,
    // drains when the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && (w_eol || w_emit)) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_eol || w_emit)) begin
            r_kind         <= w_eol;
            r_path_byte    <= w_eol ? 8'd0 : c;
            r_low_out      <= (w_eol && w_ok) ? r_low : 64'd0;
            r_high_out     <= (w_eol && w_ok) ? r_high : 64'd0;
            r_perm_out     <= (w_eol && w_ok) ? r_perm : 32'd0;
            r_perm_cnt_out <= (w_eol && w_ok) ? r_perm_seen : 3'd0;
            r_ok_out       <= w_eol && w_ok;
            r_score_out    <= (w_eol && w_ok) ? w_score : 7'd0;
            r_len_out      <= (w_eol && w_ok) ? r_path_count : 12'd0;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_path_byte   = r_path_byte;
    assign o_low_addr    = r_low_out;
    assign o_high_addr   = r_high_out;
    assign o_perm_chars  = r_perm_out;
    assign o_perm_count  = r_perm_cnt_out;
    assign o_parse_ok    = r_ok_out;
    assign o_score       = r_score_out;
    assign o_path_length = r_len_out;

    // A held result must block new requests.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |-> !o_char_ready)
        else $error("request accepted while result stalled");

    // Line end returns the parser to line start with an empty path.
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_eol) |=> (r_phase == mmlps_pkg::PH_LOW_START &&
                                 r_path_count == 12'd0 && !r_failed && o_res_valid && o_kind))
        else $error("line state not cleared after line end");

    // A failed summary carries no score.
    a_fail_no_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind && !o_parse_ok) |-> (o_score == 7'd0 && o_path_length == 12'd0))
        else $error("failed line reports a score");

endmodule
